### hdl/edfq_pkg.sv
`default_nettype none
package edfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int DL_W        = 64;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int RC_W        = 5;

    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = FUNC_W;
    localparam int M_TDATA_W   = 88;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ     = 2'd0,
        FUNC_DEQ     = 2'd1,
        FUNC_PICK    = 2'd2,
        FUNC_PREEMPT = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_FULL   = 3'd2,
        ST_DUP    = 3'd3,
        ST_ABSENT = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic id_hit;
        logic dl_le;
    } cmp_t;

endpackage
`default_nettype wire

### hdl/edfq_ram.sv
`default_nettype none
module edfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hdl/edfq_cmp.sv
`default_nettype none
module edfq_cmp (
    input  wire edfq_pkg::entry_t       entry,
    input  wire logic [edfq_pkg::ID_W-1:0] key_id,
    input  wire logic [edfq_pkg::DL_W-1:0] key_dl,
    output edfq_pkg::cmp_t              result
);

    import edfq_pkg::*;

    // dl_le: stored deadline not later than key, so the key goes behind it
    always_comb
    begin
        result.id_hit = (entry.id == key_id);
        result.dl_le  = (entry.dl <= key_dl);
    end

endmodule
`default_nettype wire

### hdl/edf_ready_queue_unit.sv
`default_nettype none
// Operation: pick, preempt check and zero-deadline enqueue go straight to the head read;
// other enqueues and dequeues first scan every queued entry and decide, then shift one
// entry per step and, on a successful enqueue, write the new entry.
// Throughput: one word at a time; the next is taken in the cycle after the result is
// registered, and a stalled result holds the next result in S_HEADCAP.
// Reset (rst_n low, async): queue empty, no result pending; RAM is not cleared.
module edf_ready_queue_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // task_id[7:0], deadline[71:8]
    input  wire logic [edfq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  wire logic [edfq_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // status[2:0], head_valid[3], head_task[11:4], head_deadline[75:12],
    // running_count[80:76], preempt[81], zero[87:82]
    output logic      [edfq_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import edfq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_DECIDE  = 7'b0000100,
        S_SHIFT   = 7'b0001000,
        S_WRNEW   = 7'b0010000,
        S_HEADRD  = 7'b0100000,
        S_HEADCAP = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    func_t                func_reg, func_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [DL_W-1:0]      dl_reg, dl_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     found_pos_reg, found_pos_next;
    logic [CNT_W-1:0]     ins_pos_reg, ins_pos_next;
    logic [IDX_W-1:0]     dst_reg, dst_next;
    status_t              status_reg, status_next;
    logic                 out_vld_reg, out_vld_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    entry_t               ram_wr_data;
    logic                 ram_rd_en;
    logic [IDX_W-1:0]     ram_rd_addr;
    entry_t               ram_rd_data;
    cmp_t                 cmp;

    logic                 head_valid;
    logic [ID_W-1:0]      head_task;
    logic [DL_W-1:0]      head_deadline;
    logic                 preempt;

    edfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    edfq_cmp u_cmp (
        .entry  (ram_rd_data),
        .key_id (id_reg),
        .key_dl (dl_reg),
        .result (cmp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    assign head_valid    = (count_reg != '0);
    assign head_task     = head_valid ? ram_rd_data.id : '0;
    assign head_deadline = head_valid ? ram_rd_data.dl : '0;
    assign preempt       = (func_reg == FUNC_PREEMPT) && head_valid && !cmp.id_hit;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        id_next        = id_reg;
        dl_next        = dl_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        ins_pos_next   = ins_pos_reg;
        dst_next       = dst_reg;
        status_next    = status_reg;
        out_vld_next   = out_vld_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next     = func_t'(s_axis_tuser);
                    id_next       = s_axis_tdata[ID_W-1:0];
                    dl_next       = s_axis_tdata[ID_W +: DL_W];
                    status_next   = ST_OK;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    ins_pos_next  = '0;
                    case (func_t'(s_axis_tuser))
                        FUNC_ENQ:
                        begin
                            if (s_axis_tdata[ID_W +: DL_W] == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_HEADRD;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        FUNC_DEQ:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_HEADRD;
                        end
                    endcase
                end
            end

            // read entry i while comparing entry i-1
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (cmp.id_hit)
                    begin
                        found_next     = 1'b1;
                        found_pos_next = pend_idx_reg;
                    end
                    if (cmp.dl_le)
                    begin
                        ins_pos_next = ins_pos_reg + CNT_W'(1);
                    end
                end
                if (scan_idx_reg < count_reg)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = scan_idx_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (func_reg == FUNC_ENQ)
                begin
                    if (found_reg)
                    begin
                        status_next = ST_DUP;
                        state_next  = S_HEADRD;
                    end
                    else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_HEADRD;
                    end
                    else if (ins_pos_reg == count_reg)
                    begin
                        state_next = S_WRNEW;
                    end
                    else
                    begin
                        dst_next    = count_reg[IDX_W-1:0];
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(count_reg - CNT_W'(1));
                        state_next  = S_SHIFT;
                    end
                end
                else
                begin
                    if (!found_reg)
                    begin
                        status_next = ST_ABSENT;
                        state_next  = S_HEADRD;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (CNT_W'(found_pos_reg) + CNT_W'(1) < count_reg)
                        begin
                            dst_next    = found_pos_reg;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = found_pos_reg + IDX_W'(1);
                            state_next  = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_HEADRD;
                        end
                    end
                end
            end

            // move one entry per cycle; read of the next source overlaps the write
            S_SHIFT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = dst_reg;
                ram_wr_data = ram_rd_data;
                if (func_reg == FUNC_ENQ)
                begin
                    if (CNT_W'(dst_reg) > ins_pos_reg + CNT_W'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = dst_reg - IDX_W'(2);
                        dst_next    = dst_reg - IDX_W'(1);
                    end
                    else
                    begin
                        state_next = S_WRNEW;
                    end
                end
                else
                begin
                    if (CNT_W'(dst_reg) + CNT_W'(1) < count_reg)
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = dst_reg + IDX_W'(2);
                        dst_next    = dst_reg + IDX_W'(1);
                    end
                    else
                    begin
                        state_next = S_HEADRD;
                    end
                end
            end

            S_WRNEW:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = ins_pos_reg[IDX_W-1:0];
                ram_wr_data.id = id_reg;
                ram_wr_data.dl = dl_reg;
                count_next     = count_reg + CNT_W'(1);
                state_next     = S_HEADRD;
            end

            S_HEADRD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                state_next  = S_HEADCAP;
            end

            S_HEADCAP:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = {6'b0, preempt, RC_W'(count_reg), head_deadline,
                                     head_task, head_valid, status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        id_reg        <= id_next;
        dl_reg        <= dl_next;
        scan_idx_reg  <= scan_idx_next;
        pend_idx_reg  <= pend_idx_next;
        found_reg     <= found_next;
        found_pos_reg <= found_pos_next;
        ins_pos_reg   <= ins_pos_next;
        dst_reg       <= dst_next;
        status_reg    <= status_next;
        out_data_reg  <= out_data_next;
    end

endmodule
`default_nettype wire

### hdl/edfq_chk.sv
`default_nettype none
module edfq_chk (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [edfq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import edfq_pkg::*;

    logic [STATUS_W-1:0] status;
    logic                head_valid;
    logic [ID_W-1:0]     head_task;
    logic [DL_W-1:0]     head_deadline;
    logic [RC_W-1:0]     running_count;
    logic                preempt;

    assign status        = m_axis_tdata[2:0];
    assign head_valid    = m_axis_tdata[3];
    assign head_task     = m_axis_tdata[11:4];
    assign head_deadline = m_axis_tdata[75:12];
    assign running_count = m_axis_tdata[80:76];
    assign preempt       = m_axis_tdata[81];

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> running_count <= RC_W'(QUEUE_DEPTH))
        else $error("running_count above queue depth");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (head_valid == (running_count != '0))
                          && (head_valid || (head_task == '0 && head_deadline == '0)))
        else $error("head fields disagree with count");

    a_preempt_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && preempt |-> head_valid && status == ST_OK)
        else $error("preempt on empty queue or failed op");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> status <= ST_ABSENT)
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed while stalled");

endmodule

bind edf_ready_queue_unit edfq_chk u_edfq_chk (.*);
`default_nettype wire
